[sv/trsc_pkg.sv]
package trsc_pkg;

   // Sector geometry
   localparam int SECTOR_BYTES = 512;
   localparam int POS_W        = $clog2(SECTOR_BYTES);

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int SECTOR_W  = 32;
   localparam int COUNT_W   = 32;
   localparam int NTLIM_W   = 13;
   localparam int WLIM_W    = 6;
   localparam int LEVEL_W   = 6;
   localparam int VERDICT_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 13;

   // Verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_NONE  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_START = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_CONT  = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_END   = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NONTEXT_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARNING_LIMIT = 1'd1;

   // Register reset values
   localparam logic [NTLIM_W-1:0] NONTEXT_LIMIT_RST = 13'd50;
   localparam logic [WLIM_W-1:0]  WARNING_LIMIT_RST = 6'd10;

   typedef struct packed {
      logic [NTLIM_W-1:0] nontext_limit;
      logic [WLIM_W-1:0]  warning_limit;
   } cfg_type;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic [SECTOR_W-1:0]  run_start_sector;
      logic [COUNT_W-1:0]   run_length;
   } result_type;

   // Printable ASCII, the whitespace controls and three high code points
   function automatic logic is_text(input logic [BYTE_W-1:0] b);
      logic res;
      res = ((b >= 8'd32) && (b <= 8'd126)) || ((b >= 8'd9) && (b <= 8'd13)) ||
            (b == 8'd153) || (b == 8'd169) || (b == 8'd174);
      return res;
   endfunction

endpackage

[sv/trsc_run_tracker.sv]
module trsc_run_tracker
   import trsc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [BYTE_W-1:0]   data_byte,
   input  logic                last_in_sector,
   input  logic [SECTOR_W-1:0] sector_number,
   input  cfg_type             cfg,
   output logic                sector_end,
   output result_type          result
);

   logic                in_run_ff,   in_run_in;
   logic [LEVEL_W-1:0]  level_ff,    level_in;
   logic                failed_ff,   failed_in;
   logic [NTLIM_W-1:0]  ntcount_ff,  ntcount_in;
   logic [COUNT_W-1:0]  run_bytes_ff, run_bytes_in;
   logic [COUNT_W-1:0]  low_off_ff,  low_off_in;
   logic [SECTOR_W-1:0] start_ff,    start_in;
   logic [POS_W-1:0]    pos_ff,      pos_in;

   logic                text;
   logic [COUNT_W-1:0]  run_inc;
   logic [LEVEL_W:0]    lvl;
   logic [COUNT_W-1:0]  run_bytes_mid;
   logic [COUNT_W-1:0]  low_off_mid;
   logic [NTLIM_W-1:0]  ntcount_mid;
   logic [LEVEL_W-1:0]  level_mid;
   logic                failed_mid;

   assign text       = is_text(data_byte);
   assign sector_end = last_in_sector || (pos_ff == POS_W'(SECTOR_BYTES - 1));
   assign run_inc    = (run_bytes_ff == '1) ? run_bytes_ff : run_bytes_ff + 1'b1;

   // Warning level step: down by one on text (floor 1), doubled otherwise
   always_comb begin
      if (text) begin
         lvl = (level_ff > LEVEL_W'(1)) ? {1'b0, level_ff - 1'b1} : (LEVEL_W+1)'(1);
      end else begin
         lvl = {level_ff, 1'b0};
      end
   end

   // Per-byte update
   always_comb begin
      run_bytes_mid = run_bytes_ff;
      low_off_mid   = low_off_ff;
      ntcount_mid   = ntcount_ff;
      level_mid     = level_ff;
      failed_mid    = failed_ff;
      if (!in_run_ff) begin
         run_bytes_mid = run_inc;
         if (!text && (ntcount_ff != '1)) begin
            ntcount_mid = ntcount_ff + 1'b1;
         end
      end else if (!failed_ff) begin
         run_bytes_mid = run_inc;
         if (lvl == (LEVEL_W+1)'(1)) begin
            low_off_mid = run_inc;
         end
         if (lvl > {1'b0, cfg.warning_limit}) begin
            failed_mid = 1'b1;
         end else begin
            level_mid = lvl[LEVEL_W-1:0];
         end
      end
   end

   // End of sector: verdict and per-sector reset
   always_comb begin
      in_run_in    = in_run_ff;
      start_in     = start_ff;
      run_bytes_in = run_bytes_mid;
      low_off_in   = low_off_mid;
      ntcount_in   = ntcount_mid;
      level_in     = level_mid;
      failed_in    = failed_mid;
      pos_in       = pos_ff + 1'b1;
      result       = '0;
      if (sector_end) begin
         if (!in_run_ff) begin
            if (ntcount_mid > cfg.nontext_limit) begin
               run_bytes_in = '0;
            end else begin
               in_run_in               = 1'b1;
               start_in                = sector_number;
               result.verdict          = VERDICT_START;
               result.run_start_sector = sector_number;
            end
         end else if (failed_mid) begin
            result.verdict          = VERDICT_END;
            result.run_start_sector = start_ff;
            result.run_length       = low_off_mid;
            in_run_in               = 1'b0;
            run_bytes_in            = '0;
         end else begin
            result.verdict          = VERDICT_CONT;
            result.run_start_sector = start_ff;
         end
         low_off_in = run_bytes_in;
         level_in   = LEVEL_W'(1);
         failed_in  = 1'b0;
         ntcount_in = '0;
         pos_in     = '0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff    <= 1'b0;
         level_ff     <= LEVEL_W'(1);
         failed_ff    <= 1'b0;
         ntcount_ff   <= '0;
         run_bytes_ff <= '0;
         low_off_ff   <= '0;
         start_ff     <= '0;
         pos_ff       <= '0;
      end else if (fire) begin
         in_run_ff    <= in_run_in;
         level_ff     <= level_in;
         failed_ff    <= failed_in;
         ntcount_ff   <= ntcount_in;
         run_bytes_ff <= run_bytes_in;
         low_off_ff   <= low_off_in;
         start_ff     <= start_in;
         pos_ff       <= pos_in;
      end
   end

   // The level never drops to zero
   a_level_nonzero: assert property (@(posedge clock) disable iff (reset)
      level_ff != '0) else $error("warning level is zero");

   // A failure is only recorded inside a run
   a_failed_in_run: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> in_run_ff) else $error("failure flag set outside a run");

   // The last low offset never runs ahead of the byte count
   a_low_off_bound: assert property (@(posedge clock) disable iff (reset)
      low_off_ff <= run_bytes_ff) else $error("last low offset beyond run bytes");

endmodule

[sv/text_run_sector_carver_top.sv]
// Text run sector carver.
// Bytes of a disk image enter on the req_ channel, one transaction per byte,
// with the sector number and a flag on the final byte of each sector. A
// sector also ends on its SECTOR_BYTES-th byte. On the final byte of each
// sector one verdict leaves on the rsp_ channel: no text, run starts, run
// continues or run ends, with the start sector and, for a run end, the run
// length in bytes up to the last byte at the lowest warning level.
// Throughput is one byte per cycle while no sector-ending byte waits on a held
// result. A byte is registered on acceptance and is then classified and folded
// into the run state; a sector's verdict is registered in the result register.
// The single result register sets the pace: when the receiver stalls, a byte
// that ends a sector waits in the input register, and bytes inside a sector
// keep flowing until one that ends a sector reaches it.
// The csr_ port writes the non-text and warning limits at any edge with
// csr_wr_en high; write them only while no transaction is in flight.
// Synchronous reset empties both registers, restores the limits to 50 and 10
// and leaves the block outside any run.
module text_run_sector_carver_top
   import trsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_last_in_sector,
   input  logic [SECTOR_W-1:0]  req_sector_number,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VERDICT_W-1:0] rsp_verdict,
   output logic [SECTOR_W-1:0]  rsp_run_start_sector,
   output logic [COUNT_W-1:0]   rsp_run_length,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wr_data
);

   logic                in_valid_ff;
   logic [BYTE_W-1:0]   in_byte_ff;
   logic                in_last_ff;
   logic [SECTOR_W-1:0] in_sector_ff;
   logic                rsp_valid_ff;
   result_type          rsp_ff;
   cfg_type             cfg_ff;

   logic                out_free;
   logic                sector_end;
   logic                fire;
   result_type          result;

   // Handshake: a byte moves on unless it ends a sector and the result is held
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && (!sector_end || out_free);
   assign req_ready = !in_valid_ff || fire;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nontext_limit <= NONTEXT_LIMIT_RST;
         cfg_ff.warning_limit <= WARNING_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NONTEXT_LIMIT: cfg_ff.nontext_limit <= csr_wr_data;
            CSR_WARNING_LIMIT: cfg_ff.warning_limit <= csr_wr_data[WLIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff   <= req_data_byte;
         in_last_ff   <= req_last_in_sector;
         in_sector_ff <= req_sector_number;
      end
   end

   trsc_run_tracker u_tracker (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .data_byte      (in_byte_ff),
      .last_in_sector (in_last_ff),
      .sector_number  (in_sector_ff),
      .cfg            (cfg_ff),
      .sector_end     (sector_end),
      .result         (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && sector_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && sector_end) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_verdict          = rsp_ff.verdict;
   assign rsp_run_start_sector = rsp_ff.run_start_sector;
   assign rsp_run_length       = rsp_ff.run_length;

   // A byte that closes a sector always leaves a verdict behind
   a_sector_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire && sector_end |=> rsp_valid_ff) else $error("sector end lost its verdict");

   // A sector without text carries no start sector and no length
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.verdict == VERDICT_NONE) |->
      (rsp_ff.run_start_sector == '0) && (rsp_ff.run_length == '0))
      else $error("no-text verdict with payload");

   // A length is only reported when a run ends
   a_length_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.verdict != VERDICT_END) |-> (rsp_ff.run_length == '0))
      else $error("run length outside a run end");

endmodule
